[rtl/rdq_pkg.sv]
// Package for the ring buffer deque: opcodes, status codes, field widths
// and the command bundle that the top level sends to every storage cell.
// No dependencies.
package rdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;
  localparam int CNT_MAX = 16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;

  localparam logic signed [DATA_W-1:0] NONE_VALUE = -32'sd1;

  typedef struct packed {
    logic put_front;
    logic put_back;
    logic take_front;
    logic take_back;
    logic clear;
  } cell_cmd_t;

endpackage

[rtl/ring_buffer_deque.sv]
// Top level of the ring buffer deque: command decode, element count,
// result stages and the chain of rdq_cell storage cells.
// Depends on rdq_pkg and rdq_cell.

// The deque is kept as a row of DEPTH cells with the front element always in
// the first cell; pushes and pops at the front shift the whole row by one
// cell, while a push at the back fills the cell after the last occupied one
// and a pop at the back clears the last occupied one. One operation is
// accepted per cycle as long as results are taken; each result passes the
// pending stage and the output register: the cells update at the transfer
// edge and the front and back values are read from them into the output
// register as the pending result moves on. The back-element selection across
// the cells sets the clock. A capacity write empties the deque; it is taken
// only with no result in the first stage; the input is held off in its cycle.
module ring_buffer_deque
  import rdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [ST_W-1:0]          out_status,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_back_value,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  output logic [CNT_W-1:0]         out_element_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_capacity
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EXT_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CAP_TOP = (1 << CNT_W) - 1;
  localparam int CAP_MAX = (DEPTH < CAP_TOP) ? DEPTH : CAP_TOP;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_occ;
  cell_cmd_t                cmd;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_used;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [EXT_W-1:0] back_ext;
  logic [IDX_W-1:0] back_idx;
  logic signed [DATA_W-1:0] back_data;

  logic in_acc;
  logic cfg_wr;
  logic is_push;
  logic is_pop;
  logic full;
  logic empty;

  logic                     pend_valid_r;
  logic                     pend_valid_nxt;
  logic signed [DATA_W-1:0] pend_popped_r;
  logic signed [DATA_W-1:0] pend_popped_nxt;
  logic [ST_W-1:0]          pend_status_r;
  logic [ST_W-1:0]          pend_status_nxt;

  logic out_load;
  logic out_valid_r;
  logic out_valid_nxt;
  logic signed [DATA_W-1:0] out_popped_r;
  logic [ST_W-1:0]          out_status_r;
  logic signed [DATA_W-1:0] out_front_r;
  logic signed [DATA_W-1:0] out_back_r;
  logic                     out_empty_r;
  logic                     out_full_r;
  logic [CNT_W-1:0]         out_count_r;

  always_comb begin
    if (cap_r == '0) begin
      cap_used = CNT_W'(1);
    end else if (cap_r > CNT_W'(CAP_MAX)) begin
      cap_used = CNT_W'(CAP_MAX);
    end else begin
      cap_used = cap_r;
    end
  end

  assign back_ext  = EXT_W'(cnt_r) - EXT_W'(1);
  assign back_idx  = back_ext[IDX_W-1:0];
  assign back_data = cell_data[back_idx];

  assign out_load  = pend_valid_r && (!out_valid_r || !out_stall);
  assign cfg_ready = !pend_valid_r;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (pend_valid_r && !out_load) || cfg_wr;
  assign in_acc    = in_valid && !in_stall;

  assign is_push = (in_opcode == OP_PUSH_FRONT) || (in_opcode == OP_PUSH_BACK);
  assign is_pop  = (in_opcode == OP_POP_FRONT) || (in_opcode == OP_POP_BACK);
  assign full    = cnt_r >= cap_used;
  assign empty   = cnt_r == '0;

  always_comb begin
    cmd            = '0;
    cmd.clear      = cfg_wr;
    cmd.put_front  = in_acc && (in_opcode == OP_PUSH_FRONT) && !full;
    cmd.put_back   = in_acc && (in_opcode == OP_PUSH_BACK) && !full;
    cmd.take_front = in_acc && (in_opcode == OP_POP_FRONT) && !empty;
    cmd.take_back  = in_acc && (in_opcode == OP_POP_BACK) && !empty;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_wr) begin
      cnt_nxt = '0;
    end else if (cmd.put_front || cmd.put_back) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.take_front || cmd.take_back) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    pend_status_nxt = ST_OK;
    if (is_push && full) begin
      pend_status_nxt = ST_OVER;
    end else if (is_pop && empty) begin
      pend_status_nxt = ST_UNDER;
    end
    if (cmd.take_front) begin
      pend_popped_nxt = cell_data[0];
    end else if (cmd.take_back) begin
      pend_popped_nxt = back_data;
    end else begin
      pend_popped_nxt = NONE_VALUE;
    end
    if (in_acc) begin
      pend_valid_nxt = 1'b1;
    end else if (out_load) begin
      pend_valid_nxt = 1'b0;
    end else begin
      pend_valid_nxt = pend_valid_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CNT_W'(CNT_MAX);
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_r <= cfg_capacity;
      end
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_popped_r <= pend_popped_nxt;
      pend_status_r <= pend_status_nxt;
    end
    if (out_load) begin
      out_popped_r <= pend_popped_r;
      out_status_r <= pend_status_r;
      out_front_r  <= empty ? NONE_VALUE : cell_data[0];
      out_back_r   <= empty ? NONE_VALUE : back_data;
      out_empty_r  <= empty;
      out_full_r   <= cnt_r == cap_used;
      out_count_r  <= cnt_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data;
    logic                     prev_occ;
    logic signed [DATA_W-1:0] next_data;
    logic                     next_occ;

    if (i == 0) begin : g_first
      assign prev_data = in_value;
      assign prev_occ  = 1'b1;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
      assign prev_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
      assign next_occ  = 1'b0;
    end else begin : g_inner
      assign next_data = cell_data[i+1];
      assign next_occ  = cell_occ[i+1];
    end

    rdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .in_value  (in_value),
      .prev_data (prev_data),
      .prev_occ  (prev_occ),
      .next_data (next_data),
      .next_occ  (next_occ),
      .data      (cell_data[i]),
      .occ       (cell_occ[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_popped_r;
  assign out_status        = out_status_r;
  assign out_front_value   = out_front_r;
  assign out_back_value    = out_back_r;
  assign out_is_empty      = out_empty_r;
  assign out_is_full       = out_full_r;
  assign out_element_count = out_count_r;

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap_used)
    else $error("element count exceeds the capacity in use");

  a_occ_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == 32'(cnt_r))
    else $error("occupied cells disagree with the element count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_front || cmd.put_back) && !cfg_wr |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("accepted push did not add one element");

  a_stall_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pend_valid_r && out_valid_r && out_stall) || cfg_wr)
    else $error("input stalled without a blocked result");
`endif

endmodule

[rtl/rdq_cell.sv]
// One storage cell of the deque chain: a data word and an occupied flag.
// Depends on rdq_pkg for the command bundle and the data width.
module rdq_cell
  import rdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic                     prev_occ,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic                     next_occ,
  output logic signed [DATA_W-1:0] data,
  output logic                     occ
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     occ_r;
  logic                     occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (cmd.clear) begin
      occ_nxt = 1'b0;
    end else if (cmd.put_front) begin
      data_nxt = prev_data;
      occ_nxt  = prev_occ;
    end else if (cmd.put_back) begin
      if (!occ_r && prev_occ) begin
        data_nxt = in_value;
      end
      occ_nxt = occ_r | prev_occ;
    end else if (cmd.take_front) begin
      data_nxt = next_data;
      occ_nxt  = next_occ;
    end else if (cmd.take_back) begin
      occ_nxt = occ_r & next_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign occ  = occ_r;

endmodule

[tb/tb_ring_buffer_deque.sv]
// Self-checking testbench for ring_buffer_deque: directed and random deque operations
// over several capacity settings, checked against a predictor that tracks the ring.
// Depends on rdq_pkg and the ring_buffer_deque RTL.
`timescale 1ns / 100ps

module tb;
  import rdq_pkg::*;

  localparam logic [OP_W-1:0] OP_PEEK = 3'd4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 183;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic              drain_first;
  } deque_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic                     empty;
    logic                     full;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_opcode = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [ST_W-1:0]          out_status;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_back_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic [CNT_W-1:0]         out_element_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_capacity = '0;

  deque_req_t    pending_ops[$];
  deque_result_t expected_results[$];
  deque_req_t    next_req;

  logic [DATA_W-1:0] ring_slots[CNT_MAX];
  int unsigned       head_slot = 0;
  int unsigned       tail_slot = 0;
  int unsigned       fill_level = 0;
  logic [CNT_W-1:0]  cap_setting = 5'd16;

  int unsigned ops_queued = 0;
  int unsigned ops_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  ring_buffer_deque #(.DEPTH(16)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_popped_value  (out_popped_value),
    .out_status        (out_status),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full),
    .out_element_count (out_element_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] value);
    int unsigned   c;
    deque_result_t res;
    c = (cap_setting == 0) ? 1 : (cap_setting > CNT_MAX) ? CNT_MAX : cap_setting;
    res.popped = NONE_VALUE;
    res.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level >= c) begin
          res.status = ST_OVER;
        end else if (fill_level == 0) begin
          head_slot = 0;
          tail_slot = 0;
          ring_slots[0] = value;
          fill_level = 1;
        end else if (op == OP_PUSH_FRONT) begin
          head_slot = (head_slot == 0 || head_slot >= c) ? c - 1 : head_slot - 1;
          ring_slots[head_slot] = value;
          fill_level++;
        end else begin
          tail_slot = (tail_slot + 1 >= c) ? 0 : tail_slot + 1;
          ring_slots[tail_slot] = value;
          fill_level++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.popped = (op == OP_POP_FRONT) ? ring_slots[head_slot] : ring_slots[tail_slot];
          fill_level--;
          if (fill_level == 0) begin
            head_slot = 0;
            tail_slot = 0;
          end else if (op == OP_POP_FRONT) begin
            head_slot = (head_slot + 1 >= c) ? 0 : head_slot + 1;
          end else begin
            tail_slot = (tail_slot == 0 || tail_slot >= c) ? c - 1 : tail_slot - 1;
          end
        end
      end
      default: ;
    endcase
    res.front = (fill_level == 0) ? NONE_VALUE : ring_slots[head_slot];
    res.back = (fill_level == 0) ? NONE_VALUE : ring_slots[tail_slot];
    res.empty = (fill_level == 0);
    res.full = (fill_level == c);
    res.count = CNT_W'(fill_level);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input deque_result_t want);
    if (out_popped_value !== want.popped)
      report_mismatch("popped_value", out_popped_value, want.popped);
    if (out_status !== want.status)
      report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
    if (out_front_value !== want.front)
      report_mismatch("front_value", out_front_value, want.front);
    if (out_back_value !== want.back)
      report_mismatch("back_value", out_back_value, want.back);
    if (out_is_empty !== want.empty)
      report_mismatch("is_empty", DATA_W'(out_is_empty), DATA_W'(want.empty));
    if (out_is_full !== want.full)
      report_mismatch("is_full", DATA_W'(out_is_full), DATA_W'(want.full));
    if (out_element_count !== want.count)
      report_mismatch("element_count", DATA_W'(out_element_count), DATA_W'(want.count));
  endtask

  task automatic add_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                        input logic drain_first);
    deque_req_t req;
    req.op = op;
    req.value = value;
    req.drain_first = drain_first;
    pending_ops.insert(pending_ops.size(), req);
    ops_queued++;
  endtask

  task automatic queue_random_ops(input int unsigned n_ops);
    int unsigned      run_left;
    int unsigned      push_pct;
    int unsigned      r;
    logic [OP_W-1:0]  op;
    logic [DATA_W-1:0] value;
    run_left = 0;
    push_pct = 50;
    for (int unsigned n = 0; n < n_ops; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        r = $urandom_range(0, 2);
        push_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
      end
      run_left--;
      if ($urandom_range(0, 99) < 5) begin
        op = OP_W'($urandom_range(4, 7));
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      r = $urandom_range(0, 9);
      value = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
              (r == 2) ? 32'hFFFF_FFFF : (r == 3) ? 32'h0 : $urandom;
      add_op(op, value, $urandom_range(0, 199) == 0);
    end
  endtask

  // Idle means every queued operation has been taken and every result checked;
  // the task then lets the two-stage result path settle before it returns.
  task automatic wait_idle();
    do @(posedge clk);
    while (ops_accepted != ops_queued || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = cap;
    head_slot = 0;
    tail_slot = 0;
    fill_level = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && (!pending_ops[0].drain_first ||
                   (!in_valid && expected_results.size() == 0))) begin
        next_req = pending_ops[0];
        pending_ops.delete(0);
        in_valid <= 1'b1;
        in_opcode <= next_req.op;
        in_value <= next_req.value;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                apply_deque_op(in_opcode, in_value));
        ops_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0)
          report_mismatch("result with nothing outstanding", out_popped_value, '0);
        else begin
          check_result(expected_results[0]);
          expected_results.delete(0);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_caps[10];
    phase_caps = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd2, CNT_W'($urandom_range(0, 31)),
                   5'd3, CNT_W'($urandom_range(0, 31)), 5'd8, 5'd5};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty deque at reset capacity: both pops underflow, peek and unknown codes change nothing.
    add_op(OP_POP_FRONT, 32'h1234_5678, 1'b0);
    add_op(OP_POP_BACK, 32'hFFFF_FFFF, 1'b0);
    add_op(OP_PEEK, 32'h0, 1'b0);
    add_op(3'd5, 32'hAAAA_AAAA, 1'b0);
    add_op(3'd6, 32'h5555_5555, 1'b0);
    add_op(3'd7, 32'h0, 1'b0);
    add_op(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    add_op(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
    add_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
    add_op(OP_PUSH_BACK, 32'h0, 1'b0);
    add_op(OP_PEEK, 32'hFFFF_FFFF, 1'b1);
    add_op(OP_POP_BACK, 32'h0, 1'b0);
    add_op(OP_POP_FRONT, 32'h0, 1'b0);
    add_op(OP_POP_FRONT, 32'h0, 1'b0);
    add_op(OP_POP_BACK, 32'h0, 1'b0);
    add_op(OP_POP_BACK, 32'h0, 1'b0);

    // Capacity of one: the second push of either kind overflows.
    write_capacity(5'd1);
    add_op(OP_PUSH_BACK, 32'hDEAD_BEEF, 1'b0);
    add_op(OP_PUSH_BACK, 32'h1111_1111, 1'b0);
    add_op(OP_PUSH_FRONT, 32'h2222_2222, 1'b0);
    add_op(OP_POP_FRONT, 32'h0, 1'b0);
    add_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
    add_op(OP_POP_BACK, 32'h0, 1'b0);

    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      idle_on = (i != 3 && i != 7);
      queue_random_ops(PHASE_ITEMS);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
